@@ hdl/spss_pkg.sv @@
package spss_pkg;

  // Number of servo channels that are smoothed.
  localparam int CHANNELS = 3;
  // Number of channels carried on the word ports.
  localparam int IO_CH = 3;

  localparam int US_W   = 12;
  localparam int FRAC_W = 8;
  localparam int POS_W  = US_W + FRAC_W;
  localparam int DB_W   = 16;
  localparam int KEEP_W = 8;
  localparam int GAIN_W = KEEP_W + 1;
  localparam int PROD_W = POS_W + GAIN_W;
  localparam int STEP_W = PROD_W - FRAC_W;

  localparam logic [US_W-1:0] CENTER_US = 12'd1500;

  // APB register file geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PULSE = 3'd0,
    REG_MAX_PULSE = 3'd1,
    REG_DEADBAND  = 3'd2,
    REG_MAX_STEP  = 3'd3,
    REG_KEEP      = 3'd4
  } reg_idx_t;

  localparam logic [US_W-1:0]   RST_MIN_PULSE = 12'd550;
  localparam logic [US_W-1:0]   RST_MAX_PULSE = 12'd2400;
  localparam logic [DB_W-1:0]   RST_DEADBAND  = 16'd1024;
  localparam logic [DB_W-1:0]   RST_MAX_STEP  = 16'd3840;
  localparam logic [KEEP_W-1:0] RST_KEEP      = 8'd38;

  typedef struct packed {
    logic [US_W-1:0]   min_pulse_us;
    logic [US_W-1:0]   max_pulse_us;
    logic [DB_W-1:0]   deadband_q8;
    logic [DB_W-1:0]   max_step_q8;
    logic [KEEP_W-1:0] keep_weight;
  } cfg_t;

  // What one lane reports for the tick under way.
  typedef struct packed {
    logic [US_W-1:0] width;
    logic            changed;
  } lane_res_t;

  // One result word.
  typedef struct packed {
    logic [IO_CH-1:0][US_W-1:0] width;
    logic [IO_CH-1:0]           mask;
  } res_t;

endpackage

@@ hdl/spss_in_if.sv @@
interface spss_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [spss_pkg::US_W-1:0]    target_a;
  logic [spss_pkg::US_W-1:0]    target_b;
  logic [spss_pkg::US_W-1:0]    target_c;

  modport source (output valid, cmd, target_a, target_b, target_c, input ready);
  modport sink   (input valid, cmd, target_a, target_b, target_c, output ready);
endinterface

@@ hdl/spss_out_if.sv @@
interface spss_out_if;
  logic                         valid;
  logic                         ready;
  logic [spss_pkg::US_W-1:0]    width_a;
  logic [spss_pkg::US_W-1:0]    width_b;
  logic [spss_pkg::US_W-1:0]    width_c;
  logic [spss_pkg::IO_CH-1:0]   changed_mask;

  modport source (output valid, width_a, width_b, width_c, changed_mask, input ready);
  modport sink   (input valid, width_a, width_b, width_c, changed_mask, output ready);
endinterface

@@ hdl/spss_cfg_regs.sv @@
module spss_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [spss_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [spss_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [spss_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output spss_pkg::cfg_t                    cfg
);

  spss_pkg::cfg_t     cfg_r;
  spss_pkg::reg_idx_t idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = spss_pkg::reg_idx_t'(paddr[spss_pkg::CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Register writes land in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_pulse_us <= spss_pkg::RST_MIN_PULSE;
      cfg_r.max_pulse_us <= spss_pkg::RST_MAX_PULSE;
      cfg_r.deadband_q8  <= spss_pkg::RST_DEADBAND;
      cfg_r.max_step_q8  <= spss_pkg::RST_MAX_STEP;
      cfg_r.keep_weight  <= spss_pkg::RST_KEEP;
    end else if (wr_en) begin
      case (idx)
        spss_pkg::REG_MIN_PULSE: cfg_r.min_pulse_us <= pwdata[spss_pkg::US_W-1:0];
        spss_pkg::REG_MAX_PULSE: cfg_r.max_pulse_us <= pwdata[spss_pkg::US_W-1:0];
        spss_pkg::REG_DEADBAND:  cfg_r.deadband_q8  <= pwdata[spss_pkg::DB_W-1:0];
        spss_pkg::REG_MAX_STEP:  cfg_r.max_step_q8  <= pwdata[spss_pkg::DB_W-1:0];
        spss_pkg::REG_KEEP:      cfg_r.keep_weight  <= pwdata[spss_pkg::KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (idx)
      spss_pkg::REG_MIN_PULSE: prdata = 32'(cfg_r.min_pulse_us);
      spss_pkg::REG_MAX_PULSE: prdata = 32'(cfg_r.max_pulse_us);
      spss_pkg::REG_DEADBAND:  prdata = 32'(cfg_r.deadband_q8);
      spss_pkg::REG_MAX_STEP:  prdata = 32'(cfg_r.max_step_q8);
      spss_pkg::REG_KEEP:      prdata = 32'(cfg_r.keep_weight);
      default:                 prdata = '0;
    endcase
  end

endmodule

@@ hdl/spss_lane.sv @@
module spss_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spss_pkg::cfg_t                cfg,
  input  logic                          set_en,
  input  logic                          tick_en,
  input  logic [spss_pkg::US_W-1:0]     target_in,
  output spss_pkg::lane_res_t           res
);

  logic [spss_pkg::US_W-1:0]   target_r;
  logic [spss_pkg::US_W-1:0]   target_nxt;
  logic [spss_pkg::POS_W-1:0]  pos_r;
  logic [spss_pkg::POS_W-1:0]  pos_nxt;
  logic [spss_pkg::US_W-1:0]   last_r;
  logic [spss_pkg::POS_W-1:0]  tq;
  logic                        up;
  logic [spss_pkg::POS_W-1:0]  mag;
  logic                        in_band;
  logic [spss_pkg::GAIN_W-1:0] gain;
  logic [spss_pkg::PROD_W-1:0] prod;
  logic [spss_pkg::STEP_W-1:0] step_raw;
  logic [spss_pkg::STEP_W-1:0] step_lim;
  logic [spss_pkg::STEP_W-1:0] step_fin;
  logic [spss_pkg::POS_W-1:0]  step;

  // Clamp the new target: raise to the minimum first, then lower to the maximum.
  always_comb begin
    target_nxt = target_in;
    if (target_nxt < cfg.min_pulse_us) target_nxt = cfg.min_pulse_us;
    if (target_nxt > cfg.max_pulse_us) target_nxt = cfg.max_pulse_us;
  end

  // Distance to target and its rounded, slew-limited step.
  assign tq       = {target_r, spss_pkg::FRAC_W'(0)};
  assign up       = tq >= pos_r;
  assign mag      = up ? (tq - pos_r) : (pos_r - tq);
  assign in_band  = mag < spss_pkg::POS_W'(cfg.deadband_q8);
  assign gain     = spss_pkg::GAIN_W'(256) - spss_pkg::GAIN_W'(cfg.keep_weight);
  assign prod     = spss_pkg::PROD_W'(mag) * spss_pkg::PROD_W'(gain)
                    + spss_pkg::PROD_W'(128);
  assign step_raw = prod[spss_pkg::PROD_W-1:spss_pkg::FRAC_W];
  assign step_lim = (step_raw > spss_pkg::STEP_W'(cfg.max_step_q8))
                    ? spss_pkg::STEP_W'(cfg.max_step_q8) : step_raw;
  assign step_fin = (step_lim > spss_pkg::STEP_W'(mag)) ? spss_pkg::STEP_W'(mag) : step_lim;
  assign step     = step_fin[spss_pkg::POS_W-1:0];

  always_comb begin
    if (in_band) begin
      pos_nxt = tq;
    end else if (up) begin
      pos_nxt = pos_r + step;
    end else begin
      pos_nxt = pos_r - step;
    end
  end

  assign res.width   = pos_nxt[spss_pkg::POS_W-1:spss_pkg::FRAC_W];
  assign res.changed = res.width != last_r;

  // Channel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= spss_pkg::CENTER_US;
      pos_r    <= {spss_pkg::CENTER_US, spss_pkg::FRAC_W'(0)};
      last_r   <= spss_pkg::CENTER_US;
    end else begin
      if (set_en) begin
        target_r <= target_nxt;
      end
      if (tick_en) begin
        pos_r  <= pos_nxt;
        last_r <= res.width;
      end
    end
  end

  // A tick never moves the position further from its target.
  a_dist_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    tick_en && !set_en |=> mag <= $past(mag))
    else $error("lane distance to target grew on a tick");

  // A stored target never exceeds the maximum in force when it was written.
  a_target_max: assert property (@(posedge clk) disable iff (!rst_n)
    set_en |=> target_r <= $past(cfg.max_pulse_us))
    else $error("lane target above maximum");

endmodule

@@ hdl/spss_merge.sv @@
module spss_merge (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       push,
  input  spss_pkg::lane_res_t [spss_pkg::CHANNELS-1:0] lane_res,
  output logic                                       can_take,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output spss_pkg::res_t                             out_res
);

  spss_pkg::res_t new_res;
  spss_pkg::res_t main_r;
  spss_pkg::res_t skid_r;
  logic           main_v_r;
  logic           skid_v_r;
  logic           pop;

  // Gather the reported channels into one word; missing channels read zero.
  for (genvar i = 0; i < spss_pkg::IO_CH; i++) begin : g_col
    if (i < spss_pkg::CHANNELS) begin : g_live
      assign new_res.width[i] = lane_res[i].width;
      assign new_res.mask[i]  = lane_res[i].changed;
    end else begin : g_none
      assign new_res.width[i] = '0;
      assign new_res.mask[i]  = 1'b0;
    end
  end

  assign pop       = main_v_r && out_ready;
  assign can_take  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_r <= new_res;
      end else begin
        skid_r <= new_res;
      end
    end
  end

  // The skid entry only fills behind a waiting word.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry valid without a main word");

  // A pushed word is always held somewhere on the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> main_v_r)
    else $error("pushed word was lost");

endmodule

@@ hdl/servo_pulse_slew_smoother.sv @@
// Channel   Role     Handshake        Word
// in_ch     sink     valid / ready    cmd, target_a, target_b, target_c
// out_ch    source   valid / ready    width_a, width_b, width_c, changed_mask
// APB       slave    psel / penable   min/max pulse, deadband, max step, keep weight
//
// One word is taken per cycle while in_ch.ready is high; each lane updates its channel
// in the cycle a tick is accepted, and the result is registered before out_ch shows it.
// The lane path (distance, one multiply by the gain, step clamp, add) sets the cycle time.
// Reset (rst_n low, synchronous) centers every position, target and last width.
// A two-entry output buffer keeps in_ch taking words in an out_ch stall until it fills.
module servo_pulse_slew_smoother (
  input  logic                              clk,
  input  logic                              rst_n,
  spss_in_if.sink                           in_ch,
  spss_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [spss_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [spss_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [spss_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  spss_pkg::cfg_t                               cfg;
  spss_pkg::lane_res_t [spss_pkg::CHANNELS-1:0] lane_res;
  spss_pkg::res_t                               out_res;
  logic [spss_pkg::IO_CH-1:0][spss_pkg::US_W-1:0] tgt;
  logic                                         can_take;
  logic                                         acc;
  logic                                         set_en;
  logic                                         tick_en;

  spss_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input word decode.
  assign in_ch.ready = can_take;
  assign acc         = in_ch.valid && can_take;
  assign set_en      = acc && !in_ch.cmd;
  assign tick_en     = acc && in_ch.cmd;
  assign tgt[0]      = in_ch.target_a;
  assign tgt[1]      = in_ch.target_b;
  assign tgt[2]      = in_ch.target_c;

  // One lane per servo channel; lanes past the word ports keep their reset target.
  for (genvar g = 0; g < spss_pkg::CHANNELS; g++) begin : g_lane
    localparam int  TIDX   = (g < spss_pkg::IO_CH) ? g : 0;
    localparam bit  HAS_IO = (g < spss_pkg::IO_CH);
    spss_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (cfg),
      .set_en    (set_en && HAS_IO),
      .tick_en   (tick_en),
      .target_in (tgt[TIDX]),
      .res       (lane_res[g])
    );
  end

  spss_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tick_en),
    .lane_res  (lane_res),
    .can_take  (can_take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.width_a      = out_res.width[0];
  assign out_ch.width_b      = out_res.width[1];
  assign out_ch.width_c      = out_res.width[2];
  assign out_ch.changed_mask = out_res.mask;

endmodule
